@@ rtl/ssc_pkg.sv @@
`default_nettype none
package ssc_pkg;

    localparam int COORD_W  = 24;
    localparam int RADIUS_W = 23;
    localparam int DEPTH_W  = 24;
    localparam int DIR_W    = 16;
    localparam int DIFF_W   = 25;
    localparam int SQ_W     = 51;
    localparam int ROOT_W   = 26;
    localparam int RSUM_W   = 24;
    localparam int DIR_FRAC = 14;
    localparam int MAG_W    = 24;
    localparam int NUM_W    = MAG_W + DIR_FRAC;

    typedef struct packed {
        logic signed [COORD_W-1:0]  center_a_x;
        logic signed [COORD_W-1:0]  center_a_y;
        logic signed [COORD_W-1:0]  center_a_z;
        logic        [RADIUS_W-1:0] radius_a;
        logic signed [COORD_W-1:0]  center_b_x;
        logic signed [COORD_W-1:0]  center_b_y;
        logic signed [COORD_W-1:0]  center_b_z;
        logic        [RADIUS_W-1:0] radius_b;
    } in_word_t;

    typedef struct packed {
        logic                      touching;
        logic        [DEPTH_W-1:0] depth;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [DIR_W-1:0]   dir_z;
    } out_word_t;

endpackage
`default_nettype wire

@@ rtl/ssc_div_pipe.sv @@
`default_nettype none
// restoring divider, one quotient bit per stage: q = num / den (den != 0), num < den*2^15
module ssc_div_pipe (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic [ssc_pkg::NUM_W-1:0]    num,
    input  wire logic [ssc_pkg::ROOT_W-1:0]   den,
    output logic      [ssc_pkg::DIR_FRAC:0]   quo
);
    localparam int QB = ssc_pkg::DIR_FRAC + 1;
    localparam int RW = ssc_pkg::ROOT_W + 1;

    logic [ssc_pkg::NUM_W-1:0]  num_reg [QB+1];
    logic [ssc_pkg::ROOT_W-1:0] den_reg [QB+1];
    logic [RW-1:0]              rem_reg [QB+1];
    logic [QB-1:0]              q_reg   [QB+1];

    always_comb begin
        num_reg[0] = num;
        den_reg[0] = den;
        rem_reg[0] = '0;
        q_reg[0]   = '0;
    end

    for (genvar i = 0; i < QB; i++) begin : g_st
        // bits above the top QB positions of the quotient are zero by the range of num
        localparam int BIT = QB - 1 - i;
        logic [RW:0] trial;
        logic [RW:0] sub;
        if (i == 0) begin : g_first
            always_comb begin
                trial = (RW+1)'(num_reg[i][ssc_pkg::NUM_W-1:BIT]);
                sub   = trial - {2'b0, den_reg[i]};
            end
        end else begin : g_next
            always_comb begin
                trial = {rem_reg[i], num_reg[i][BIT]};
                sub   = trial - {2'b0, den_reg[i]};
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[i+1] <= num_reg[i];
                den_reg[i+1] <= den_reg[i];
                if (!sub[RW]) begin
                    rem_reg[i+1] <= sub[RW-1:0];
                    q_reg[i+1]   <= q_reg[i] | (QB'(1) << BIT);
                end else begin
                    rem_reg[i+1] <= trial[RW-1:0];
                    q_reg[i+1]   <= q_reg[i];
                end
            end
        end
    end

    assign quo = q_reg[QB];
endmodule
`default_nettype wire

@@ rtl/sphere_sphere_contact_top.sv @@
`default_nettype none
// Sphere-sphere contact test, fully pipelined.
// s_ channel: one word per pair (two centers and radii, signed fixed point).
// m_ channel: one word per pair: touching flag, depth, unit direction Q1.14.
// Throughput: one word per cycle while m_ready does not stall the output.
// Stages from the accepting s_ edge to m_valid: 3 arithmetic stages,
// 26 root stages, compare stage, 15 divider stages, output register.
// The pipeline advances as a whole; when m_ready is low and the output
// register is full, every stage holds and s_ready falls, so no word is
// lost or repeated. An empty bubble is squeezed only by the output stage.
// Reset (aresetn low, synchronous) clears all valid bits; payload is not
// reset. Depth = rsum - distance; direction is D*16384/distance with the
// magnitude truncated and zero when centers coincide or no contact.
module sphere_sphere_contact_top #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire ssc_pkg::in_word_t    s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ssc_pkg::out_word_t        m_data
);
    localparam int DW = ssc_pkg::DIFF_W;
    localparam int RW = ssc_pkg::ROOT_W;
    localparam int RS = ssc_pkg::RSUM_W;
    localparam int SW = ssc_pkg::SQ_W;
    localparam int NR = RW;                       // root stages
    localparam int ND = ssc_pkg::DIR_FRAC + 1;    // divider stages
    localparam int SQ_PAD = 2 * RW;

    // FRAC_BITS leaves the arithmetic unchanged; it only bounds the Q format
    localparam logic FMT_OK = (FRAC_BITS >= 4) && (FRAC_BITS <= 20);

    logic en;
    logic out_full_reg;
    assign en      = !out_full_reg || m_ready;
    assign s_ready = en && FMT_OK;

    // stage 1: differences, radius sum
    logic              v1_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;
    logic [RS-1:0]     rs1_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg  <= DW'(s_data.center_b_x) - DW'(s_data.center_a_x);
            dy_reg  <= DW'(s_data.center_b_y) - DW'(s_data.center_a_y);
            dz_reg  <= DW'(s_data.center_b_z) - DW'(s_data.center_a_z);
            rs1_reg <= RS'(s_data.radius_a) + RS'(s_data.radius_b);
        end
    end

    // stage 2: squares
    logic                  v2_reg;
    logic [2*DW-1:0]       qx_reg, qy_reg, qz_reg;
    logic signed [DW-1:0]  dx2_reg, dy2_reg, dz2_reg;
    logic [RS-1:0]         rs2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            qx_reg  <= (2*DW)'(dx_reg * dx_reg);
            qy_reg  <= (2*DW)'(dy_reg * dy_reg);
            qz_reg  <= (2*DW)'(dz_reg * dz_reg);
            dx2_reg <= dx_reg;
            dy2_reg <= dy_reg;
            dz2_reg <= dz_reg;
            rs2_reg <= rs1_reg;
        end
    end

    // stage 3: sum of squares
    logic                  v3_reg;
    logic [SQ_PAD-1:0]     sq_reg;
    logic signed [DW-1:0]  dx3_reg, dy3_reg, dz3_reg;
    logic [RS-1:0]         rs3_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg  <= SQ_PAD'(SW'(qx_reg) + SW'(qy_reg) + SW'(qz_reg));
            dx3_reg <= dx2_reg;
            dy3_reg <= dy2_reg;
            dz3_reg <= dz2_reg;
            rs3_reg <= rs2_reg;
        end
    end

    // root pipeline: one result bit per stage
    logic [SQ_PAD-1:0]    rn_reg  [NR+1];
    logic [RW+1:0]        rr_reg  [NR+1];
    logic [RW-1:0]        rq_reg  [NR+1];
    logic signed [DW-1:0] rdx_reg [NR+1];
    logic signed [DW-1:0] rdy_reg [NR+1];
    logic signed [DW-1:0] rdz_reg [NR+1];
    logic [RS-1:0]        rrs_reg [NR+1];
    logic                 rv_reg  [NR+1];

    always_comb begin
        rn_reg[0]  = sq_reg;
        rr_reg[0]  = '0;
        rq_reg[0]  = '0;
        rdx_reg[0] = dx3_reg;
        rdy_reg[0] = dy3_reg;
        rdz_reg[0] = dz3_reg;
        rrs_reg[0] = rs3_reg;
        rv_reg[0]  = v3_reg;
    end

    for (genvar i = 0; i < NR; i++) begin : g_root
        logic [RW+1:0] trial;
        logic [RW+1:0] sub;
        always_comb begin
            trial = {rr_reg[i][RW-1:0], rn_reg[i][SQ_PAD-1-2*i -: 2]};
            sub   = trial - {rq_reg[i], 2'b01};
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rv_reg[i+1] <= 1'b0;
            end else if (en) begin
                rv_reg[i+1] <= rv_reg[i];
            end
            if (en) begin
                rn_reg[i+1]  <= rn_reg[i];
                rdx_reg[i+1] <= rdx_reg[i];
                rdy_reg[i+1] <= rdy_reg[i];
                rdz_reg[i+1] <= rdz_reg[i];
                rrs_reg[i+1] <= rrs_reg[i];
                if (!sub[RW+1]) begin
                    rr_reg[i+1] <= sub;
                    rq_reg[i+1] <= {rq_reg[i][RW-2:0], 1'b1};
                end else begin
                    rr_reg[i+1] <= trial;
                    rq_reg[i+1] <= {rq_reg[i][RW-2:0], 1'b0};
                end
            end
        end
    end

    // compare stage after root
    logic                 vc_reg, tc_reg, zc_reg;
    logic [ssc_pkg::DEPTH_W-1:0] dep_reg;
    logic [RW-1:0]        len_reg;
    logic [ssc_pkg::NUM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic                 sx_reg, sy_reg, sz_reg;
    logic [RW-1:0]        len_n;
    logic [DW-1:0]        ax, ay, az;
    always_comb begin
        len_n = rq_reg[NR];
        ax = rdx_reg[NR][DW-1] ? DW'(-rdx_reg[NR]) : DW'(rdx_reg[NR]);
        ay = rdy_reg[NR][DW-1] ? DW'(-rdy_reg[NR]) : DW'(rdy_reg[NR]);
        az = rdz_reg[NR][DW-1] ? DW'(-rdz_reg[NR]) : DW'(rdz_reg[NR]);
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            tc_reg  <= {{(RW-RS){1'b0}}, rrs_reg[NR]} >= len_n;
            zc_reg  <= len_n == '0;
            dep_reg <= ssc_pkg::DEPTH_W'(RW'(rrs_reg[NR]) - len_n);
            len_reg <= (len_n == '0) ? RW'(1) : len_n;
            nx_reg  <= {ssc_pkg::MAG_W'(ax), {ssc_pkg::DIR_FRAC{1'b0}}};
            ny_reg  <= {ssc_pkg::MAG_W'(ay), {ssc_pkg::DIR_FRAC{1'b0}}};
            nz_reg  <= {ssc_pkg::MAG_W'(az), {ssc_pkg::DIR_FRAC{1'b0}}};
            sx_reg  <= rdx_reg[NR][DW-1];
            sy_reg  <= rdy_reg[NR][DW-1];
            sz_reg  <= rdz_reg[NR][DW-1];
        end
    end

    logic [ssc_pkg::DIR_FRAC:0] qx, qy, qz;
    ssc_div_pipe u_div_x (.aclk(aclk), .en(en), .num(nx_reg), .den(len_reg), .quo(qx));
    ssc_div_pipe u_div_y (.aclk(aclk), .en(en), .num(ny_reg), .den(len_reg), .quo(qy));
    ssc_div_pipe u_div_z (.aclk(aclk), .en(en), .num(nz_reg), .den(len_reg), .quo(qz));

    // side pipe matching the divider depth
    logic       dv_reg  [ND+1];
    logic [3+2+ssc_pkg::DEPTH_W-1:0] ds_reg [ND+1];
    always_comb begin
        dv_reg[0] = vc_reg;
        ds_reg[0] = {sx_reg, sy_reg, sz_reg, tc_reg, zc_reg, dep_reg};
    end
    for (genvar j = 0; j < ND; j++) begin : g_side
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[j+1] <= 1'b0;
            end else if (en) begin
                dv_reg[j+1] <= dv_reg[j];
            end
            if (en) begin
                ds_reg[j+1] <= ds_reg[j];
            end
        end
    end

    logic                 s_sx, s_sy, s_sz, s_t, s_z;
    logic [ssc_pkg::DEPTH_W-1:0] s_dep;
    ssc_pkg::out_word_t   res;
    always_comb begin
        {s_sx, s_sy, s_sz, s_t, s_z, s_dep} = ds_reg[ND];
        res = '0;
        if (s_t) begin
            res.touching = 1'b1;
            res.depth    = s_dep;
            if (!s_z) begin
                res.dir_x = s_sx ? -ssc_pkg::DIR_W'(qx) : ssc_pkg::DIR_W'(qx);
                res.dir_y = s_sy ? -ssc_pkg::DIR_W'(qy) : ssc_pkg::DIR_W'(qy);
                res.dir_z = s_sz ? -ssc_pkg::DIR_W'(qz) : ssc_pkg::DIR_W'(qz);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            vc_reg       <= 1'b0;
            out_full_reg <= 1'b0;
        end else if (en) begin
            v1_reg       <= s_valid && s_ready;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            vc_reg       <= rv_reg[NR];
            out_full_reg <= dv_reg[ND];
        end
        if (en) begin
            m_data <= res;
        end
    end

    assign m_valid = out_full_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken during output stall");
    a_notouch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.touching |-> m_data.depth == '0 && m_data.dir_x == '0)
        else $error("nonzero fields without contact");
endmodule
`default_nettype wire

@@ tb/sv/tb_sphere_sphere_contact_top.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_sphere_sphere_contact_top;

    localparam int LATENCY = 45;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_RANDOM = 650;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    ssc_pkg::in_word_t s_data;
    logic m_valid;
    logic m_ready;
    ssc_pkg::out_word_t m_data;

    sphere_sphere_contact_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    typedef struct {
        ssc_pkg::in_word_t  word;
        bit                 known;
        ssc_pkg::out_word_t result;
    } stim_row_t;

    ssc_pkg::out_word_t contact_q[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [25:0] floor_sqrt(logic [50:0] n);
        logic [25:0] root;
        logic [25:0] trial;
        root = '0;
        for (int b = 25; b >= 0; b--) begin
            trial = root | (26'd1 << b);
            if ({26'd0, trial} * {26'd0, trial} <= {1'b0, n}) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic logic signed [15:0] unit_comp(logic signed [24:0] d, logic [25:0] len);
        logic [24:0] mag;
        logic [63:0] q;
        if (len == 0) begin
            return '0;
        end
        mag = d < 0 ? -d : d;
        q = ({39'd0, mag} << 14) / {38'd0, len};
        return d < 0 ? -q[15:0] : q[15:0];
    endfunction

    function automatic ssc_pkg::out_word_t predict_contact(ssc_pkg::in_word_t w);
        ssc_pkg::out_word_t r;
        logic signed [24:0] dx, dy, dz;
        logic [50:0] sq;
        logic [25:0] len;
        logic [23:0] rsum;
        dx = 25'(w.center_b_x) - 25'(w.center_a_x);
        dy = 25'(w.center_b_y) - 25'(w.center_a_y);
        dz = 25'(w.center_b_z) - 25'(w.center_a_z);
        sq = 51'(dx * dx) + 51'(dy * dy) + 51'(dz * dz);
        len = floor_sqrt(sq);
        rsum = {1'b0, w.radius_a} + {1'b0, w.radius_b};
        r = '0;
        if (len <= {2'b0, rsum}) begin
            r.touching = 1'b1;
            r.depth = rsum - len[23:0];
            r.dir_x = unit_comp(dx, len);
            r.dir_y = unit_comp(dy, len);
            r.dir_z = unit_comp(dz, len);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic ssc_pkg::in_word_t make_pair(int ax, int ay, int az, int ra,
                                                    int bx, int by, int bz, int rb);
        ssc_pkg::in_word_t w;
        w.center_a_x = 24'(ax); w.center_a_y = 24'(ay); w.center_a_z = 24'(az);
        w.radius_a = 23'(ra);
        w.center_b_x = 24'(bx); w.center_b_y = 24'(by); w.center_b_z = 24'(bz);
        w.radius_b = 23'(rb);
        return w;
    endfunction

    function automatic logic [23:0] rand_coord(int spread);
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(0, 2 * spread)) - spread);
            2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            default: return 24'($signed($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    function automatic ssc_pkg::in_word_t rand_pair();
        ssc_pkg::in_word_t w;
        int spread;
        spread = 1 << $urandom_range(4, 22);
        w.center_a_x = rand_coord(spread);
        w.center_a_y = rand_coord(spread);
        w.center_a_z = rand_coord(spread);
        w.center_b_x = $urandom_range(0, 3) == 0
                     ? 24'(w.center_a_x + 24'($urandom_range(0, 40)) - 24'd20)
                     : rand_coord(spread);
        w.center_b_y = rand_coord(spread);
        w.center_b_z = rand_coord(spread);
        w.radius_a = $urandom_range(0, 4) == 0 ? 23'($urandom) : 23'($urandom_range(0, spread));
        w.radius_b = $urandom_range(0, 4) == 0 ? 23'($urandom) : 23'($urandom_range(0, spread));
        if ($urandom_range(0, 9) == 0) begin
            w.center_b_x = w.center_a_x;
            w.center_b_y = w.center_a_y;
            w.center_b_z = w.center_a_z;
        end
        return w;
    endfunction

    task automatic send_word(ssc_pkg::in_word_t w);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_data <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (contact_q.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    always @(negedge aclk) begin
        if (aresetn) begin
            m_ready <= !($urandom_range(0, 99) < recv_idle_pct);
        end else begin
            m_ready <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        ssc_pkg::out_word_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (s_valid && s_ready) begin
                contact_q.push_back(predict_contact(s_data));
            end
            if (m_valid && m_ready) begin
                if (contact_q.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    want = contact_q.pop_front();
                    if (m_data.touching !== want.touching)
                        report_mismatch("touching", m_data.touching, want.touching);
                    if (m_data.depth !== want.depth)
                        report_mismatch("depth", m_data.depth, want.depth);
                    if (m_data.dir_x !== want.dir_x)
                        report_mismatch("dir_x", m_data.dir_x, want.dir_x);
                    if (m_data.dir_y !== want.dir_y)
                        report_mismatch("dir_y", m_data.dir_y, want.dir_y);
                    if (m_data.dir_z !== want.dir_z)
                        report_mismatch("dir_z", m_data.dir_z, want.dir_z);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        stim_row_t rows[$];
        stim_row_t row;
        ssc_pkg::out_word_t fixed;
        ssc_pkg::in_word_t w;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // all zero: coincident, zero radii, touching with zero depth
        row.word = '0; row.known = 1'b1; row.result = '0; row.result.touching = 1'b1;
        rows.push_back(row);
        // coincident with max radii: depth is the full sum
        row.word = make_pair(100, -5, 7, 23'h7FFFFF, 100, -5, 7, 23'h7FFFFF);
        fixed = '0; fixed.touching = 1'b1; fixed.depth = 24'hFFFFFE;
        row.known = 1'b1; row.result = fixed; rows.push_back(row);
        // far apart, zero radii: no contact
        row.word = make_pair(-8388608, -8388608, -8388608, 0, 8388607, 8388607, 8388607, 0);
        row.known = 1'b1; row.result = '0; rows.push_back(row);
        // axis aligned contacts give exact unit directions
        row.word = make_pair(0, 0, 0, 4096, 4096, 0, 0, 4096);
        fixed = '0; fixed.touching = 1'b1; fixed.depth = 24'd4096; fixed.dir_x = 16'sd16384;
        row.known = 1'b1; row.result = fixed; rows.push_back(row);
        row.word = make_pair(0, 0, 0, 4096, 0, -4096, 0, 4096);
        fixed = '0; fixed.touching = 1'b1; fixed.depth = 24'd4096; fixed.dir_y = -16'sd16384;
        row.known = 1'b1; row.result = fixed; rows.push_back(row);
        row.word = make_pair(0, 0, 4096, 0, 0, 0, 0, 4096);
        fixed = '0; fixed.touching = 1'b1; fixed.depth = 24'd0; fixed.dir_z = -16'sd16384;
        row.known = 1'b1; row.result = fixed; rows.push_back(row);
        row.known = 1'b0;
        row.word = make_pair(-8388608, 8388607, -8388608, 23'h7FFFFF,
                             8388607, -8388608, 8388607, 23'h7FFFFF);
        rows.push_back(row);
        row.word = make_pair(8388607, 8388607, 8388607, 23'h7FFFFF,
                             -8388608, -8388608, -8388608, 23'h7FFFFF);
        rows.push_back(row);
        row.word = make_pair(0, 0, 0, 3, 3, 4, 0, 2); rows.push_back(row);
        row.word = make_pair(0, 0, 0, 2, 3, 4, 0, 2); rows.push_back(row);
        row.word = make_pair(1, 1, 1, 0, 2, 2, 2, 1); rows.push_back(row);
        row.word = make_pair(-1, 0, 0, 0, 0, 0, 0, 1); rows.push_back(row);
        row.word = make_pair(-5000, 12000, -700, 9000, 3000, -2000, 500, 9000);
        rows.push_back(row);

        foreach (rows[i]) begin
            send_word(rows[i].word);
            if (rows[i].known && predict_contact(rows[i].word) != rows[i].result) begin
                report_mismatch("directed row table", i, i);
            end
        end
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = ph == 0 ? 30 : ph == 1 ? 87 : 0;
            recv_idle_pct = ph == 0 ? 87 : ph == 1 ? 30 : 0;
            for (int n = 0; n < N_RANDOM / 3; n++) begin
                w = rand_pair();
                send_word(w);
                if (n == 60) begin
                    drain();
                end
            end
        end

        drain();
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0 && contact_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
